// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    // Field widths of the stream words.
    localparam int REQ_W      = 2;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int HOME_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 8;
    localparam int USED_W     = 8;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 88;

    // Request operations.
    localparam logic [REQ_W-1:0] OP_PUT = 2'd0;
    localparam logic [REQ_W-1:0] OP_GET = 2'd1;
    localparam logic [REQ_W-1:0] OP_POP = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_SHIFT,
        S_FINISH,
        S_DONE
    } lpht_state_t;

    typedef struct packed {
        logic                load_req;
        logic                home_sub;
        logic                start_probe;
        logic                advance;
        logic                step_clr;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                mark_slot;
        logic                take_val;
        logic                take_key;
        logic                write_entry;
        logic                move_entry;
        logic                set_hole;
        logic                clear_hole;
        logic                clear_write;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                out_load;
    } lpht_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic             key_zero;
        logic             value_zero;
        logic             load_full;
        logic             home_ge;
        logic             rd_empty;
        logic             rd_match;
        logic             step_last;
        logic             clr_last;
        logic             out_free;
    } lpht_stat_t;

endpackage

// ===== rtl/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing over SLOTS slots of key/value pairs.
// Requests arrive on the s_ stream: s_tuser carries the operation (put, get, pop) and
// s_tdata the key, value and home slot. One result word per request leaves on the
// m_ stream with status, found value, removed key, slot index and entries in use.
// Probing reads one slot per cycle from the slot memory, which has one read and one
// write port. A pop goes on reading the slots after the match, up to and including
// the empty slot that ends the run, and then clears the last hole. When SLOTS is
// below 256, the home slot is first brought into range by repeated subtraction of
// SLOTS. The next word can be taken in the cycle in which the result appears, and
// the load is kept under half of SLOTS.
// After reset the block sweeps the memory to empty, one slot per cycle, with
// s_tready low. One request is worked on at a time; a new word is taken while the
// previous result still waits in the output register, and the block holds its
// finished result until m_tready frees that register.
module linear_probe_hash_table #(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // key [31:0], value [63:32], home_slot [71:64]
    input  logic [lpht_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type [1:0]
    input  logic [lpht_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status [1:0], found_value [33:2], removed_key [65:34], slot_index [73:66],
    // entries_used [81:74], zero [87:82]
    output logic [lpht_pkg::M_TDATA_W-1:0]     m_tdata
);

    lpht_pkg::lpht_cmd_t  cmd;
    lpht_pkg::lpht_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_datapath #(
        .SLOTS      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/lpht_ctrl.sv =====
module lpht_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lpht_pkg::lpht_stat_t   stat,
    output lpht_pkg::lpht_cmd_t    cmd
);

    lpht_pkg::lpht_state_t state_reg;
    lpht_pkg::lpht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            lpht_pkg::S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            lpht_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = lpht_pkg::S_CHECK;
                end
            end
            lpht_pkg::S_CHECK:
            begin
                if (!(stat.op inside {lpht_pkg::OP_PUT, lpht_pkg::OP_GET, lpht_pkg::OP_POP}))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lpht_pkg::ST_INVALID;
                    state_next     = lpht_pkg::S_DONE;
                end
                else if (stat.op == lpht_pkg::OP_PUT && (stat.key_zero || stat.value_zero))
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lpht_pkg::ST_INVALID;
                    state_next     = lpht_pkg::S_DONE;
                end
                else if (stat.op == lpht_pkg::OP_PUT && stat.load_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = lpht_pkg::ST_FULL;
                    state_next     = lpht_pkg::S_DONE;
                end
                else if (stat.home_ge)
                begin
                    // Reduce the home slot into range one subtraction a cycle.
                    cmd.home_sub = 1'b1;
                end
                else
                begin
                    cmd.start_probe = 1'b1;
                    state_next      = lpht_pkg::S_PROBE;
                end
            end
            lpht_pkg::S_PROBE:
            begin
                if (stat.rd_empty)
                begin
                    if (stat.op == lpht_pkg::OP_PUT)
                    begin
                        cmd.write_entry = 1'b1;
                        cmd.mark_slot   = 1'b1;
                        cmd.cnt_inc     = 1'b1;
                    end
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = lpht_pkg::ST_NOTFOUND;
                    end
                    state_next = lpht_pkg::S_DONE;
                end
                else if (stat.op != lpht_pkg::OP_PUT && stat.rd_match)
                begin
                    cmd.mark_slot = 1'b1;
                    cmd.take_val  = 1'b1;
                    if (stat.op == lpht_pkg::OP_POP)
                    begin
                        cmd.set_hole = 1'b1;
                        cmd.cnt_dec  = 1'b1;
                        cmd.advance  = 1'b1;
                        cmd.step_clr = 1'b1;
                        state_next   = lpht_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = lpht_pkg::S_DONE;
                    end
                end
                else if (stat.step_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = (stat.op == lpht_pkg::OP_PUT) ? lpht_pkg::ST_FULL
                                                                   : lpht_pkg::ST_NOTFOUND;
                    state_next     = lpht_pkg::S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            lpht_pkg::S_SHIFT:
            begin
                if (stat.rd_empty)
                begin
                    state_next = lpht_pkg::S_FINISH;
                end
                else
                begin
                    // A later entry with the same key moves back into the hole.
                    if (stat.rd_match)
                    begin
                        cmd.move_entry = 1'b1;
                        cmd.take_val   = 1'b1;
                    end
                    if (stat.step_last)
                    begin
                        state_next = lpht_pkg::S_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            lpht_pkg::S_FINISH:
            begin
                cmd.clear_hole = 1'b1;
                cmd.take_key   = 1'b1;
                state_next     = lpht_pkg::S_DONE;
            end
            lpht_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lpht_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lpht_datapath.sv =====
module lpht_datapath #(
    parameter int SLOTS      = 256,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lpht_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [lpht_pkg::S_TUSER_W-1:0]      s_tuser,
    input  lpht_pkg::lpht_cmd_t                 cmd,
    output lpht_pkg::lpht_stat_t                stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lpht_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LOAD_LIMIT = SLOTS / 2;
    localparam int PAD_W      = lpht_pkg::M_TDATA_W - lpht_pkg::STATUS_W - lpht_pkg::VALUE_W
                                - lpht_pkg::KEY_W - lpht_pkg::SLOT_OUT_W - lpht_pkg::USED_W;

    logic [KEY_BITS-1:0]   key_mem   [SLOTS];
    logic [VALUE_BITS-1:0] value_mem [SLOTS];

    logic [lpht_pkg::REQ_W-1:0]    op_reg;
    logic [KEY_BITS-1:0]           key_reg;
    logic [VALUE_BITS-1:0]         value_reg;
    logic [lpht_pkg::HOME_W-1:0]   home_reg;
    logic [AW-1:0]                 idx_reg;
    logic [AW-1:0]                 hole_reg;
    logic [AW-1:0]                 step_reg;
    logic [AW-1:0]                 clr_reg;
    logic [AW-1:0]                 cnt_reg;
    logic [KEY_BITS-1:0]           rd_key_reg;
    logic [VALUE_BITS-1:0]         rd_value_reg;
    logic [lpht_pkg::STATUS_W-1:0] status_reg;
    logic [VALUE_BITS-1:0]         fval_reg;
    logic [KEY_BITS-1:0]           rkey_reg;
    logic [AW-1:0]                 slot_reg;
    logic                          m_tvalid_reg;
    logic [lpht_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [AW-1:0]                 idx_plus;
    logic [AW-1:0]                 rd_addr;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [KEY_BITS-1:0]           wr_key;
    logic [VALUE_BITS-1:0]         wr_value;
    logic [lpht_pkg::USED_W-1:0]   used_out;

    assign idx_plus = (idx_reg == AW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;

    // The read address always follows idx_reg, so the read word matches idx_reg.
    always_comb
    begin
        if (cmd.start_probe)
        begin
            rd_addr = AW'(home_reg);
        end
        else if (cmd.advance)
        begin
            rd_addr = idx_plus;
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    always_comb
    begin
        wr_en    = 1'b1;
        wr_addr  = hole_reg;
        wr_key   = '0;
        wr_value = '0;
        if (cmd.clear_write)
        begin
            wr_addr = clr_reg;
        end
        else if (cmd.write_entry)
        begin
            wr_addr  = idx_reg;
            wr_key   = key_reg;
            wr_value = value_reg;
        end
        else if (cmd.move_entry)
        begin
            wr_key   = rd_key_reg;
            wr_value = rd_value_reg;
        end
        else if (!cmd.clear_hole)
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg     <= s_tuser;
            key_reg    <= KEY_BITS'(s_tdata[31:0]);
            value_reg  <= VALUE_BITS'(s_tdata[63:32]);
            home_reg   <= s_tdata[71:64];
            status_reg <= lpht_pkg::ST_OK;
            fval_reg   <= '0;
            rkey_reg   <= '0;
            slot_reg   <= '0;
        end
        else
        begin
            if (cmd.home_sub)
            begin
                home_reg <= lpht_pkg::HOME_W'(32'(home_reg) - 32'(SLOTS));
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
            end
            if (cmd.mark_slot)
            begin
                slot_reg <= idx_reg;
            end
            if (cmd.take_val)
            begin
                fval_reg <= rd_value_reg;
            end
            if (cmd.take_key)
            begin
                rkey_reg <= key_reg;
            end
        end
        if (cmd.start_probe || cmd.advance)
        begin
            idx_reg <= rd_addr;
        end
        if (cmd.set_hole || cmd.move_entry)
        begin
            hole_reg <= idx_reg;
        end
        if (cmd.start_probe || cmd.step_clr)
        begin
            step_reg <= '0;
        end
        else if (cmd.advance)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    assign used_out = (32'(cnt_reg) > 32'd255) ? 8'hFF : lpht_pkg::USED_W'(cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {PAD_W'(0), used_out, lpht_pkg::SLOT_OUT_W'(slot_reg),
                            lpht_pkg::KEY_W'(rkey_reg), lpht_pkg::VALUE_W'(fval_reg),
                            status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.clear_write)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.op         = op_reg;
    assign stat.key_zero   = (key_reg == '0);
    assign stat.value_zero = (value_reg == '0);
    assign stat.load_full  = (32'(cnt_reg) + 32'd1) >= 32'(LOAD_LIMIT);
    assign stat.home_ge    = (32'(home_reg) >= 32'(SLOTS));
    assign stat.rd_empty   = (rd_key_reg == '0);
    assign stat.rd_match   = (rd_key_reg == key_reg);
    assign stat.step_last  = (step_reg == AW'(SLOTS - 1));
    assign stat.clr_last   = (clr_reg == AW'(SLOTS - 1));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/lpht_checker.sv =====
module lpht_checker #(
    parameter int SLOTS = 256
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lpht_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int LIMIT    = SLOTS / 2 - 1;
    localparam int USED_MAX = (LIMIT > 255) ? 255 : LIMIT;

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while a request is in work");

    a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != lpht_pkg::ST_OK |-> m_tdata[73:2] == '0)
        else $error("failed request reports nonzero value, key or slot");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {24'd0, m_tdata[81:74]} <= 32'(USED_MAX))
        else $error("entries in use exceed the load limit");

    a_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == lpht_pkg::ST_OK && m_tdata[65:34] != '0
        |-> m_tdata[33:2] != '0)
        else $error("pop removed an entry with a zero value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

endmodule

bind linear_probe_hash_table lpht_checker #(.SLOTS(SLOTS)) u_lpht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
